// ----- rtl/cbor_enc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package cbor_enc_pkg;

    localparam int          BUFFER_BYTES_DEF = 4096;
    localparam int          CAP_W            = 13;
    localparam int          ADDR_W           = 12;
    localparam int          SIZE_W           = 13;
    localparam int          VALUE_W          = 64;
    localparam int          QUEUE_DEPTH      = 2;
    localparam logic [12:0] CAP_RESET        = 13'd4096;

    localparam logic [2:0] MAJ_UINT  = 3'd0;
    localparam logic [2:0] MAJ_NINT  = 3'd1;
    localparam logic [2:0] MAJ_TEXT  = 3'd3;
    localparam logic [2:0] MAJ_ARRAY = 3'd4;
    localparam logic [2:0] MAJ_MAP   = 3'd5;

    localparam logic [4:0] INFO_ARG8  = 5'd24;
    localparam logic [4:0] INFO_ARG16 = 5'd25;
    localparam logic [4:0] INFO_ARG32 = 5'd26;
    localparam logic [4:0] INFO_ARG64 = 5'd27;

    localparam logic [7:0] BYTE_FALSE = 8'hF4;
    localparam logic [7:0] BYTE_TRUE  = 8'hF5;
    localparam logic [7:0] BYTE_NULL  = 8'hF6;

    typedef enum logic [2:0] {
        OP_UNSIGNED = 3'd0,
        OP_SIGNED   = 3'd1,
        OP_BOOL     = 3'd2,
        OP_NULL     = 3'd3,
        OP_TEXT     = 3'd4,
        OP_ARRAY    = 3'd5,
        OP_MAP      = 3'd6,
        OP_RAW      = 3'd7
    } t_op;

    // one classified item: bytes to write and the state it leaves behind
    typedef struct packed {
        logic [7:0]        prefix;
        logic [63:0]       tail;
        logic [3:0]        n_bytes;
        logic              fail;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
        logic              overflow;
    } t_desc;

endpackage
`default_nettype wire

// ----- rtl/cbor_enc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cbor_enc_front
    import cbor_enc_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [CAP_W-1:0]   i_cfg_wr_data,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [2:0]         i_operation,
    input  wire logic [VALUE_W-1:0] i_value,
    output logic                    o_push,
    input  wire logic               i_push_ready,
    output t_desc                   o_desc
);

    localparam int POS_W = $clog2(BUFFER_BYTES + 1);
    localparam int EFF_W = (POS_W > CAP_W) ? POS_W : CAP_W;
    localparam logic [EFF_W-1:0] BUF_LIMIT = EFF_W'(BUFFER_BYTES);

    logic [CAP_W-1:0] r_cap;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_ovf, n_ovf;

    logic [2:0]         major;
    logic [63:0]        arg;
    logic               simple;
    logic [7:0]         simple_byte;
    logic [7:0]         prefix;
    logic [3:0]         tlen;
    logic [63:0]        aligned;
    logic [EFF_W-1:0]   cap_ext, cap_eff, pos_ext, room;
    logic               prefix_ok, tail_ok, fail;
    logic [3:0]         n_bytes;
    logic               accept;

    always_comb begin
        major       = MAJ_UINT;
        arg         = i_value;
        simple      = 1'b0;
        simple_byte = 8'd0;
        unique case (t_op'(i_operation))
            OP_UNSIGNED: major = MAJ_UINT;
            OP_SIGNED: begin
                if (i_value[63]) begin
                    major = MAJ_NINT;
                    arg   = ~i_value;
                end
            end
            OP_BOOL: begin
                simple      = 1'b1;
                simple_byte = i_value[0] ? BYTE_TRUE : BYTE_FALSE;
            end
            OP_NULL: begin
                simple      = 1'b1;
                simple_byte = BYTE_NULL;
            end
            OP_TEXT:  major = MAJ_TEXT;
            OP_ARRAY: major = MAJ_ARRAY;
            OP_MAP:   major = MAJ_MAP;
            OP_RAW: begin
                simple      = 1'b1;
                simple_byte = i_value[7:0];
            end
        endcase
    end

    always_comb begin
        aligned = arg;
        priority if (simple) begin
            prefix = simple_byte;
            tlen   = 4'd0;
        end else if (arg < 64'd24) begin
            prefix = {major, arg[4:0]};
            tlen   = 4'd0;
        end else if (arg[63:8] == 56'd0) begin
            prefix  = {major, INFO_ARG8};
            tlen    = 4'd1;
            aligned = {arg[7:0], 56'd0};
        end else if (arg[63:16] == 48'd0) begin
            prefix  = {major, INFO_ARG16};
            tlen    = 4'd2;
            aligned = {arg[15:0], 48'd0};
        end else if (arg[63:32] == 32'd0) begin
            prefix  = {major, INFO_ARG32};
            tlen    = 4'd4;
            aligned = {arg[31:0], 32'd0};
        end else begin
            prefix = {major, INFO_ARG64};
            tlen   = 4'd8;
        end
    end

    always_comb begin
        cap_ext   = EFF_W'(r_cap);
        cap_eff   = (cap_ext > BUF_LIMIT) ? BUF_LIMIT : cap_ext;
        pos_ext   = EFF_W'(r_pos);
        room      = (pos_ext >= cap_eff) ? '0 : cap_eff - pos_ext;
        prefix_ok = (room != '0);
        tail_ok   = (EFF_W'(tlen) < room);
        fail      = !(prefix_ok && tail_ok);
        if (!prefix_ok) begin
            n_bytes = 4'd0;
        end else if (tail_ok) begin
            n_bytes = 4'd1 + tlen;
        end else begin
            n_bytes = 4'd1;
        end
        n_pos = POS_W'(r_pos + POS_W'(n_bytes));
        n_ovf = r_ovf | fail;
    end

    assign accept  = i_valid && i_push_ready;
    assign o_ready = i_push_ready;
    assign o_push  = i_valid;

    always_comb begin
        o_desc.prefix   = prefix;
        o_desc.tail     = aligned;
        o_desc.n_bytes  = n_bytes;
        o_desc.fail     = fail;
        o_desc.addr     = ADDR_W'(r_pos);
        o_desc.size     = SIZE_W'(n_pos);
        o_desc.overflow = n_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
            r_pos <= '0;
            r_ovf <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            if (accept) begin
                r_pos <= n_pos;
                r_ovf <= n_ovf;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/cbor_enc_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cbor_enc_queue
    import cbor_enc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    output logic       o_push_ready,
    input  wire t_desc i_desc,
    output logic       o_pop_valid,
    input  wire logic  i_pop,
    output t_desc      o_desc
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    t_desc            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_push_ready = (r_count != FULL_CNT);
    assign o_pop_valid  = (r_count != '0);
    assign o_desc       = r_mem[r_rd_ptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        unique case ({do_push, do_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/cbor_enc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cbor_enc_back
    import cbor_enc_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_pop_valid,
    output logic              o_pop,
    input  wire t_desc        i_desc,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic              o_write_enable,
    output logic [ADDR_W-1:0] o_address,
    output logic [7:0]        o_data_byte,
    output logic              o_last,
    output logic              o_success,
    output logic              o_overflow,
    output logic [SIZE_W-1:0] o_size
);

    logic [3:0]        r_k, n_k;
    logic              r_valid;
    logic              r_we;
    logic [ADDR_W-1:0] r_addr;
    logic [7:0]        r_data;
    logic              r_last, r_success, r_ovf;
    logic [SIZE_W-1:0] r_size;

    logic              advance;
    logic [3:0]        total;
    logic              is_last, is_byte;
    logic [2:0]        tail_idx;
    logic [7:0]        tail_byte, data;

    assign advance  = i_pop_valid && (!r_valid || i_ready);
    assign total    = i_desc.n_bytes + {3'd0, i_desc.fail};
    assign is_last  = (r_k == total - 4'd1);
    assign is_byte  = (r_k < i_desc.n_bytes);
    assign tail_idx = 3'(r_k - 4'd1);
    assign o_pop    = advance && is_last;

    always_comb begin
        tail_byte = i_desc.tail[63 - 8 * tail_idx -: 8];
        if (!is_byte) begin
            data = 8'd0;
        end else if (r_k == 4'd0) begin
            data = i_desc.prefix;
        end else begin
            data = tail_byte;
        end
        n_k = r_k;
        if (advance) begin
            n_k = is_last ? 4'd0 : r_k + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k     <= 4'd0;
            r_valid <= 1'b0;
        end else begin
            r_k <= n_k;
            if (advance) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_we      <= is_byte;
            r_addr    <= is_byte ? ADDR_W'(i_desc.addr + ADDR_W'(r_k)) : '0;
            r_data    <= data;
            r_last    <= is_last;
            r_success <= is_last && !i_desc.fail;
            r_ovf     <= i_desc.overflow;
            r_size    <= i_desc.size;
        end
    end

    assign o_valid        = r_valid;
    assign o_write_enable = r_we;
    assign o_address      = r_addr;
    assign o_data_byte    = r_data;
    assign o_last         = r_last;
    assign o_success      = r_success;
    assign o_overflow     = r_ovf;
    assign o_size         = r_size;

endmodule
`default_nettype wire

// ----- rtl/cbor_item_head_encoder.sv -----
// an accepted item is held in the queue, then its first result is registered in
// the output stage; the byte writer gives one result per cycle while the receiver is
// ready, and an item gives 1 to 9 results, one per byte written plus one when it fails
// the front takes one item per cycle while the two-entry queue has room
// reset (synchronous, active low): position and overflow flag cleared, capacity 4096,
// queue and output stage empty
`timescale 1ns / 1ps
`default_nettype none
module cbor_item_head_encoder
    import cbor_enc_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [CAP_W-1:0]   i_cfg_wr_data,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [2:0]         i_operation,
    input  wire logic [VALUE_W-1:0] i_value,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic                    o_write_enable,
    output logic [ADDR_W-1:0]       o_address,
    output logic [7:0]              o_data_byte,
    output logic                    o_last,
    output logic                    o_success,
    output logic                    o_overflow,
    output logic [SIZE_W-1:0]       o_size
);

    logic  push, push_ready, pop_valid, pop;
    t_desc front_desc, head_desc;

    cbor_enc_front #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_operation  (i_operation),
        .i_value      (i_value),
        .o_push       (push),
        .i_push_ready (push_ready),
        .o_desc       (front_desc)
    );

    cbor_enc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_push_ready(push_ready),
        .i_desc      (front_desc),
        .o_pop_valid (pop_valid),
        .i_pop       (pop),
        .o_desc      (head_desc)
    );

    cbor_enc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pop_valid   (pop_valid),
        .o_pop         (pop),
        .i_desc        (head_desc),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_write_enable(o_write_enable),
        .o_address     (o_address),
        .o_data_byte   (o_data_byte),
        .o_last        (o_last),
        .o_success     (o_success),
        .o_overflow    (o_overflow),
        .o_size        (o_size)
    );

endmodule
`default_nettype wire

// ----- tb/cbor_head_write_checker.sv -----
`timescale 1ns / 1ps
module cbor_head_write_checker
    import cbor_enc_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [CAP_W-1:0]   i_cfg_wr_data,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_ready,
    input  wire logic [2:0]         i_operation,
    input  wire logic [VALUE_W-1:0] i_value,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_ready,
    input  wire logic               i_write_enable,
    input  wire logic [ADDR_W-1:0]  i_address,
    input  wire logic [7:0]         i_data_byte,
    input  wire logic               i_last,
    input  wire logic               i_success,
    input  wire logic               i_overflow,
    input  wire logic [SIZE_W-1:0]  i_size,
    output int unsigned             o_fail_count,
    output int unsigned             o_pending,
    output int unsigned             o_position,
    output int unsigned             o_items,
    output int unsigned             o_results,
    output int unsigned             o_rejected
);

    typedef struct packed {
        logic              write_enable;
        logic [ADDR_W-1:0] address;
        logic [7:0]        data_byte;
        logic              last;
        logic              success;
        logic              overflow;
        logic [SIZE_W-1:0] size;
    } t_buf_write;

    t_buf_write       expected_writes[$];
    t_buf_write       item_writes[$];
    logic [CAP_W-1:0] capacity = CAP_RESET;
    logic [31:0]      position = '0;
    logic             ovf_sticky = 1'b0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_position   = 0;
        o_items      = 0;
        o_results    = 0;
        o_rejected   = 0;
    end

    function automatic int unsigned room_left();
        int unsigned usable;
        usable = (capacity > BUFFER_BYTES) ? BUFFER_BYTES : capacity;
        return (position >= usable) ? 0 : usable - position;
    endfunction

    function automatic void add_item_write(input t_buf_write w);
        item_writes.insert(item_writes.size(), w);
    endfunction

    function automatic bit put_byte(input logic [7:0] data);
        t_buf_write w;
        if (room_left() == 0) begin
            ovf_sticky = 1'b1;
            return 1'b0;
        end
        w              = '0;
        w.write_enable = 1'b1;
        w.address      = position[ADDR_W-1:0];
        w.data_byte    = data;
        add_item_write(w);
        position = position + 1;
        return 1'b1;
    endfunction

    function automatic bit put_head(input logic [2:0] major, input logic [63:0] arg);
        int unsigned tail_len;
        int unsigned k;
        logic [4:0]  info;
        if (arg < 24)
            return put_byte({major, arg[4:0]});
        if (arg <= 64'hff) begin
            tail_len = 1;
            info     = INFO_ARG8;
        end else if (arg <= 64'hffff) begin
            tail_len = 2;
            info     = INFO_ARG16;
        end else if (arg <= 64'hffff_ffff) begin
            tail_len = 4;
            info     = INFO_ARG32;
        end else begin
            tail_len = 8;
            info     = INFO_ARG64;
        end
        if (!put_byte({major, info}))
            return 1'b0;
        // tail is checked as a whole, the prefix stays written
        if (tail_len > room_left()) begin
            ovf_sticky = 1'b1;
            return 1'b0;
        end
        for (k = tail_len; k > 0; k--)
            void'(put_byte(arg[(k - 1) * 8 +: 8]));
        return 1'b1;
    endfunction

    function automatic void encode_item(input logic [2:0] op, input logic [63:0] arg);
        bit         ok;
        int         n;
        t_buf_write w;
        item_writes.delete();
        case (t_op'(op))
            OP_UNSIGNED: ok = put_head(MAJ_UINT, arg);
            OP_SIGNED:   ok = arg[63] ? put_head(MAJ_NINT, ~arg) : put_head(MAJ_UINT, arg);
            OP_BOOL:     ok = put_byte(arg[0] ? BYTE_TRUE : BYTE_FALSE);
            OP_NULL:     ok = put_byte(BYTE_NULL);
            OP_TEXT:     ok = put_head(MAJ_TEXT, arg);
            OP_ARRAY:    ok = put_head(MAJ_ARRAY, arg);
            OP_MAP:      ok = put_head(MAJ_MAP, arg);
            default:     ok = put_byte(arg[7:0]);
        endcase
        if (!ok) begin
            add_item_write('0);
            o_rejected++;
        end
        n = item_writes.size();
        item_writes[n - 1].last    = 1'b1;
        item_writes[n - 1].success = ok;
        foreach (item_writes[i]) begin
            w          = item_writes[i];
            w.overflow = ovf_sticky;
            w.size     = position[SIZE_W-1:0];
            expected_writes.insert(expected_writes.size(), w);
        end
    endfunction

    function automatic void note_failure();
        o_fail_count++;
    endfunction

    always @(posedge i_clk) begin
        t_buf_write got;
        t_buf_write want;
        if (!i_rst_n) begin
            expected_writes.delete();
            capacity   = CAP_RESET;
            position   = '0;
            ovf_sticky = 1'b0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_results++;
                got = '{i_write_enable, i_address, i_data_byte, i_last, i_success,
                        i_overflow, i_size};
                if (expected_writes.size() == 0) begin
                    note_failure();
                    if (o_fail_count <= 10)
                        $display("%0t: unexpected result we=%0b addr=%0d data=%02h last=%0b",
                                 $realtime, got.write_enable, got.address, got.data_byte,
                                 got.last);
                end else begin
                    want = expected_writes.pop_front();
                    if (got !== want) begin
                        note_failure();
                        if (o_fail_count <= 10) begin
                            $display("%0t: mismatch on result %0d", $realtime, o_results);
                            $display("  expected we=%0b addr=%0d data=%02h last=%0b",
                                     want.write_enable, want.address, want.data_byte,
                                     want.last, " ok=%0b ovf=%0b size=%0d",
                                     want.success, want.overflow, want.size);
                            $display("  actual   we=%0b addr=%0d data=%02h last=%0b",
                                     got.write_enable, got.address, got.data_byte,
                                     got.last, " ok=%0b ovf=%0b size=%0d",
                                     got.success, got.overflow, got.size);
                        end
                    end
                end
            end
            if (i_cfg_wr_en)
                capacity = i_cfg_wr_data;
            if (i_in_valid && i_in_ready) begin
                o_items++;
                encode_item(i_operation, i_value);
            end
        end
        o_pending  = expected_writes.size();
        o_position = position;
    end

endmodule

// ----- tb/cbor_item_head_encoder_tb.sv -----
`timescale 1ns / 1ps
module cbor_item_head_encoder_tb;
    import cbor_enc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef enum logic [1:0] {
        SINK_FREE,
        SINK_COIN,
        SINK_SLOW,
        SINK_PATTERN
    } t_sink_mode;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_wr_en = 1'b0;
    logic [CAP_W-1:0]   i_cfg_wr_data = '0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [2:0]         i_operation = OP_UNSIGNED;
    logic [VALUE_W-1:0] i_value = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic               o_write_enable;
    logic [ADDR_W-1:0]  o_address;
    logic [7:0]         o_data_byte;
    logic               o_last;
    logic               o_success;
    logic               o_overflow;
    logic [SIZE_W-1:0]  o_size;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned position;
    int unsigned items_in;
    int unsigned results_out;
    int unsigned rejected;

    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;
    int unsigned cap_writes = 0;
    t_sink_mode  sink_mode = SINK_FREE;
    int unsigned sink_left = 0;
    int unsigned sink_phase = 0;

    cbor_item_head_encoder i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_operation    (i_operation),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_write_enable (o_write_enable),
        .o_address      (o_address),
        .o_data_byte    (o_data_byte),
        .o_last         (o_last),
        .o_success      (o_success),
        .o_overflow     (o_overflow),
        .o_size         (o_size)
    );

    cbor_head_write_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_operation    (i_operation),
        .i_value        (i_value),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_write_enable (o_write_enable),
        .i_address      (o_address),
        .i_data_byte    (o_data_byte),
        .i_last         (o_last),
        .i_success      (o_success),
        .i_overflow     (o_overflow),
        .i_size         (o_size),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_position     (position),
        .o_items        (items_in),
        .o_results      (results_out),
        .o_rejected     (rejected)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("Verification failed");
            $finish;
        end
    end

    // receiver back-pressure; the mode is picked anew at random when its run ends
    always @(negedge i_clk) begin
        if (sink_left == 0) begin
            sink_mode = t_sink_mode'($urandom_range(0, 3));
            sink_left = $urandom_range(16, 80);
        end
        sink_left--;
        sink_phase++;
        case (sink_mode)
            SINK_FREE:    i_ready <= 1'b1;
            SINK_COIN:    i_ready <= 1'($urandom_range(0, 1));
            SINK_SLOW:    i_ready <= ($urandom_range(0, 3) == 0);
            SINK_PATTERN: i_ready <= ((sink_phase % 5) < 3);
        endcase
    end

    task automatic send_item(input t_op op, input logic [63:0] arg);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = $urandom_range(0, 6);
            if (gap != 0) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_operation <= op;
        i_value     <= arg;
        burst_left--;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_valid    <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= cap;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cap_writes++;
    endtask

    function automatic logic [63:0] pick_arg();
        logic [63:0] full;
        full = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: return 64'($urandom_range(0, 23));
            1: return {56'd0, full[7:0]};
            2: return {48'd0, full[15:0]};
            3: return {32'd0, full[31:0]};
            4: return full;
            default: begin
                case ($urandom_range(0, 7))
                    0: return 64'd23;
                    1: return 64'd24;
                    2: return 64'hff;
                    3: return 64'h100;
                    4: return 64'hffff;
                    5: return 64'h1_0000;
                    6: return 64'hffff_ffff;
                    default: return 64'h1_0000_0000;
                endcase
            end
        endcase
    endfunction

    task automatic run_random(input int unsigned count);
        int unsigned sent;
        int unsigned run_len;
        int unsigned k;
        t_op         op;
        logic [63:0] arg;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 2) == 0) begin
                // a text string with its payload, or an array with its elements
                run_len = $urandom_range(0, 6);
                op      = $urandom_range(0, 1) ? OP_TEXT : OP_ARRAY;
                send_item(op, 64'(run_len));
                for (k = 0; k < run_len; k++) begin
                    if (op == OP_TEXT)
                        send_item(OP_RAW, {$urandom, $urandom});
                    else
                        send_item(t_op'($urandom_range(0, 3)), pick_arg());
                end
                sent += run_len + 1;
            end else begin
                op  = t_op'($urandom_range(0, 7));
                arg = pick_arg();
                if (op == OP_SIGNED && $urandom_range(0, 1))
                    arg = ~arg;
                send_item(op, arg);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_capacity(CAP_RESET);
        send_item(OP_UNSIGNED, 64'd0);
        send_item(OP_UNSIGNED, 64'd23);
        send_item(OP_UNSIGNED, 64'd24);
        send_item(OP_UNSIGNED, 64'hff);
        send_item(OP_UNSIGNED, 64'h100);
        send_item(OP_UNSIGNED, 64'hffff);
        send_item(OP_UNSIGNED, 64'h1_0000);
        send_item(OP_UNSIGNED, 64'hffff_ffff);
        send_item(OP_UNSIGNED, 64'h1_0000_0000);
        send_item(OP_UNSIGNED, '1);
        send_item(OP_SIGNED, '1);
        send_item(OP_SIGNED, 64'hffff_ffff_ffff_ffe8);
        send_item(OP_SIGNED, 64'hffff_ffff_ffff_ffe7);
        send_item(OP_SIGNED, 64'h8000_0000_0000_0000);
        send_item(OP_SIGNED, 64'd100);
        send_item(OP_BOOL, 64'hffff_ffff_ffff_fffe);
        send_item(OP_BOOL, 64'd1);
        send_item(OP_NULL, '1);
        send_item(OP_TEXT, 64'd23);
        send_item(OP_ARRAY, 64'd24);
        send_item(OP_MAP, 64'h1_0000_0000);
        send_item(OP_RAW, '1);
        send_item(OP_RAW, 64'd0);
        settle();

        // tail that exactly fills the room, then nothing left
        write_capacity(CAP_W'(position + 3));
        send_item(OP_UNSIGNED, 64'd300);
        send_item(OP_UNSIGNED, 64'd0);
        settle();

        // prefix written, tail rejected; then a single byte with no room
        write_capacity(CAP_W'(position + 1));
        send_item(OP_UNSIGNED, 64'd1000);
        send_item(OP_UNSIGNED, 64'd7);
        send_item(OP_BOOL, 64'd1);
        settle();

        write_capacity(CAP_W'(position + 3));
        send_item(OP_UNSIGNED, 64'h100_0000_0000);
        send_item(OP_RAW, 64'h5a);
        send_item(OP_ARRAY, 64'd300);
        send_item(OP_MAP, 64'd5);
        settle();

        // capacity below the write position
        write_capacity('0);
        send_item(OP_NULL, 64'd0);
        send_item(OP_TEXT, 64'd3);
        settle();

        // capacity above the buffer size
        write_capacity('1);
        run_random(115);
        settle();

        write_capacity(CAP_W'(position + $urandom_range(8, 40)));
        run_random(70);
        settle();

        // flag stays set while writes go through again
        write_capacity(CAP_RESET);
        run_random(100);
        settle();

        repeat (16) @(negedge i_clk);
        $display("run: %0d items in, %0d results checked, %0d operations rejected for lack of room",
                 items_in, results_out, rejected);
        $display("run: %0d capacity writes, %0d buffer bytes in use at the end, %0d errors",
                 cap_writes, position, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/cbor_enc_pkg.sv
rtl/cbor_enc_front.sv
rtl/cbor_enc_queue.sv
rtl/cbor_enc_back.sv
rtl/cbor_item_head_encoder.sv
tb/cbor_head_write_checker.sv
tb/cbor_item_head_encoder_tb.sv
